// File: design/kjst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kjst_pkg: shared types and constants of the keyed job slot table
// Commands, status codes, sequencer states and the item payloads.
// ----------------------------------------------------------------------------
package kjst_pkg;

  // Table geometry
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int SCAN_W     = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int SLOTN_W = 6;
  localparam int REF_W   = 8;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 14;

  localparam logic [REF_W-1:0]   REF_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ATTACH = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_END    = 3'd2,
    CMD_CLEAN  = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_RESP
  } state_e;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   job_key;
    logic [KEY_W-1:0]   step_key;
    logic [SLOTN_W-1:0] slot_number;
    logic [REF_W-1:0]   app_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOTN_W-1:0] found_slot;
    logic [TOTAL_W-1:0] job_count;
    logic               was_new;
  } out_item_t;

  // One slot entry as stored in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0] job_key;
    logic [KEY_W-1:0] step_key;
    logic [REF_W-1:0] refcount;
  } entry_t;

  // What the scan unit has gathered over one pass
  typedef struct packed {
    logic               match_found;
    logic [SLOT_W-1:0]  match_idx;
    logic [REF_W-1:0]   match_cnt;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic [TOTAL_W-1:0] total;
  } scan_res_t;

endpackage
`default_nettype wire

// File: design/kjst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kjst_if: valid/ready channels of the keyed job slot table
// One channel for command items, one for result items.
// ----------------------------------------------------------------------------
interface kjst_in_if;
  logic               valid;
  logic               ready;
  kjst_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kjst_out_if;
  logic                valid;
  logic                ready;
  kjst_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/kjst_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kjst_slot_ram: slot key and reference count storage
// One read port with registered data, one write port; keys and count are
// written separately so a count update leaves the keys alone.
// ----------------------------------------------------------------------------
module kjst_slot_ram (
  input  wire logic                                 clk_i,
  input  wire logic                                 rd_en_i,
  input  wire logic [kjst_pkg::SLOT_W-1:0]          rd_addr_i,
  output kjst_pkg::entry_t                          rd_data_o,
  input  wire logic                                 wr_key_en_i,
  input  wire logic                                 wr_cnt_en_i,
  input  wire logic [kjst_pkg::SLOT_W-1:0]          wr_addr_i,
  input  wire kjst_pkg::entry_t                     wr_data_i
);

  logic [2*kjst_pkg::KEY_W-1:0] key_mem [kjst_pkg::SLOT_COUNT];
  logic [kjst_pkg::REF_W-1:0]   cnt_mem [kjst_pkg::SLOT_COUNT];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_key_en_i) begin
      key_mem[wr_addr_i] <= {wr_data_i.job_key, wr_data_i.step_key};
    end
    if (wr_cnt_en_i) begin
      cnt_mem[wr_addr_i] <= wr_data_i.refcount;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      {rd_data_o.job_key, rd_data_o.step_key} <= key_mem[rd_addr_i];
      rd_data_o.refcount                      <= cnt_mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/kjst_scan_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kjst_scan_unit: shared compare and accumulate unit
// Looks at one slot per cycle while step_i is high: key compare, first
// match, first free slot, saturating sum of max(count,1) over used slots.
// ----------------------------------------------------------------------------
module kjst_scan_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          step_i,
  input  wire logic [kjst_pkg::SLOT_W-1:0]   idx_i,
  input  wire logic                          entry_valid_i,
  input  wire kjst_pkg::entry_t              entry_i,
  input  wire logic [kjst_pkg::KEY_W-1:0]    job_key_i,
  input  wire logic [kjst_pkg::KEY_W-1:0]    step_key_i,
  input  wire logic                          by_slot_i,
  output kjst_pkg::scan_res_t                res_o
);

  kjst_pkg::scan_res_t res_q, res_d;
  logic                        hit;
  logic [kjst_pkg::REF_W-1:0]  add_val;
  logic [kjst_pkg::TOTAL_W:0]  sum;

  // Compare and add for the slot at hand
  always_comb begin
    hit     = entry_valid_i &&
              (by_slot_i || (entry_i.job_key == job_key_i && entry_i.step_key == step_key_i));
    add_val = (entry_i.refcount == '0) ? kjst_pkg::REF_W'(1) : entry_i.refcount;
    sum     = {1'b0, res_q.total} + (kjst_pkg::TOTAL_W + 1)'(add_val);
  end

  // Fold the slot into the running result
  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d = '0;
    end else if (step_i) begin
      if (hit && !res_q.match_found) begin
        res_d.match_found = 1'b1;
        res_d.match_idx   = idx_i;
        res_d.match_cnt   = entry_i.refcount;
      end
      if (!entry_valid_i && !res_q.free_found) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = idx_i;
      end
      if (entry_valid_i) begin
        res_d.total = sum[kjst_pkg::TOTAL_W] ? kjst_pkg::TOTAL_MAX
                                             : sum[kjst_pkg::TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// File: design/keyed_job_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Attach, find, clean and count scan all slots, one per cycle through
//   the slot memory read port.
// End reads only its own slot.
// Throughput: one item at a time; ready returns the cycle after the result is taken.
// Reset: asynchronous, active low; clears all slot valid bits and the sequencer.
// ----------------------------------------------------------------------------
// keyed_job_slot_table: keyed table of job slots with reference counts
// A small sequencer walks the slot memory through a shared scan unit, then
// applies the command's update and holds the result.
// ----------------------------------------------------------------------------
module keyed_job_slot_table (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kjst_in_if.sink    in_i,
  kjst_out_if.source out_o
);

  localparam int SW = kjst_pkg::SLOT_W;
  localparam int CW = kjst_pkg::SCAN_W;

  kjst_pkg::state_e state_q, state_d;

  // Captured command
  kjst_pkg::in_item_t cmd_q;
  logic               range_bad_q;

  // Scan sequencing
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] last_q, last_d;
  logic          rd_vld_q;
  logic [SW-1:0] rd_idx_q;
  logic          rd_en;

  logic [kjst_pkg::SLOT_COUNT-1:0] valid_q, valid_d;

  kjst_pkg::entry_t    rd_data;
  kjst_pkg::entry_t    wr_data;
  logic                wr_key_en, wr_cnt_en;
  logic [SW-1:0]       wr_addr;
  kjst_pkg::scan_res_t scan_res;
  kjst_pkg::out_item_t res_d, res_q;

  logic accept;
  logic end_cmd;
  logic clear_scan;

  assign accept  = in_i.valid && in_i.ready;
  assign end_cmd = (in_i.payload.command == kjst_pkg::CMD_END);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kjst_pkg::S_IDLE:  if (accept) state_d = kjst_pkg::S_SCAN;
      kjst_pkg::S_SCAN:  if (cnt_q == last_q) state_d = kjst_pkg::S_DRAIN;
      kjst_pkg::S_DRAIN: state_d = kjst_pkg::S_APPLY;
      kjst_pkg::S_APPLY: state_d = kjst_pkg::S_RESP;
      kjst_pkg::S_RESP:  if (out_o.ready) state_d = kjst_pkg::S_IDLE;
      default:           state_d = kjst_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_i.ready  = (state_q == kjst_pkg::S_IDLE);
    out_o.valid = (state_q == kjst_pkg::S_RESP);
    rd_en       = (state_q == kjst_pkg::S_SCAN);
    clear_scan  = accept;
  end

  // Scan address range: end looks at its own slot only
  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    if (accept) begin
      if (end_cmd && ({1'b0, in_i.payload.slot_number} < 7'(kjst_pkg::SLOT_COUNT))) begin
        cnt_d  = CW'(in_i.payload.slot_number);
        last_d = CW'(in_i.payload.slot_number);
      end else if (end_cmd) begin
        cnt_d  = '0;
        last_d = '0;
      end else begin
        cnt_d  = '0;
        last_d = CW'(kjst_pkg::SLOT_COUNT - 1);
      end
    end else if (rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kjst_pkg::S_IDLE;
      cnt_q    <= '0;
      last_q   <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      rd_vld_q <= rd_en;
      valid_q  <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= in_i.payload;
      range_bad_q <= ({1'b0, in_i.payload.slot_number} >= 7'(kjst_pkg::SLOT_COUNT));
    end
    if (rd_en) begin
      rd_idx_q <= cnt_q[SW-1:0];
    end
    if (state_q == kjst_pkg::S_APPLY) begin
      res_q <= res_d;
    end
  end

  kjst_slot_ram u_ram (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (cnt_q[SW-1:0]),
    .rd_data_o   (rd_data),
    .wr_key_en_i (wr_key_en),
    .wr_cnt_en_i (wr_cnt_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data)
  );

  kjst_scan_unit u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear_scan),
    .step_i        (rd_vld_q),
    .idx_i         (rd_idx_q),
    .entry_valid_i (valid_q[rd_idx_q]),
    .entry_i       (rd_data),
    .job_key_i     (cmd_q.job_key),
    .step_key_i    (cmd_q.step_key),
    .by_slot_i     (cmd_q.command == kjst_pkg::CMD_END),
    .res_o         (scan_res)
  );

  // Apply the command once the scan is complete
  always_comb begin
    valid_d          = valid_q;
    wr_key_en        = 1'b0;
    wr_cnt_en        = 1'b0;
    wr_addr          = scan_res.match_idx;
    wr_data.job_key  = cmd_q.job_key;
    wr_data.step_key = cmd_q.step_key;
    wr_data.refcount = scan_res.match_cnt;
    res_d            = '0;
    res_d.status     = kjst_pkg::ST_OK;
    if (state_q == kjst_pkg::S_APPLY) begin
      case (cmd_q.command)
        kjst_pkg::CMD_ATTACH: begin
          if (scan_res.match_found) begin
            wr_cnt_en        = 1'b1;
            wr_data.refcount = (scan_res.match_cnt == kjst_pkg::REF_MAX) ?
                               scan_res.match_cnt : scan_res.match_cnt + 8'd1;
            res_d.found_slot = kjst_pkg::SLOTN_W'(scan_res.match_idx);
          end else if (scan_res.free_found) begin
            wr_key_en                 = 1'b1;
            wr_cnt_en                 = 1'b1;
            wr_addr                   = scan_res.free_idx;
            wr_data.refcount          = cmd_q.app_count;
            valid_d[scan_res.free_idx] = 1'b1;
            res_d.found_slot          = kjst_pkg::SLOTN_W'(scan_res.free_idx);
            res_d.was_new             = 1'b1;
          end else begin
            res_d.status = kjst_pkg::ST_FULL;
          end
        end
        kjst_pkg::CMD_FIND: begin
          if (scan_res.match_found) begin
            res_d.found_slot = kjst_pkg::SLOTN_W'(scan_res.match_idx);
          end else begin
            res_d.status = kjst_pkg::ST_MISSING;
          end
        end
        kjst_pkg::CMD_END: begin
          if (range_bad_q) begin
            res_d.status = kjst_pkg::ST_MISSING;
          end else if (!scan_res.match_found) begin
            res_d.status     = kjst_pkg::ST_MISSING;
            res_d.found_slot = cmd_q.slot_number;
          end else begin
            res_d.found_slot = cmd_q.slot_number;
            wr_cnt_en        = 1'b1;
            if (scan_res.match_cnt <= 8'd1) begin
              wr_data.refcount            = '0;
              valid_d[scan_res.match_idx] = 1'b0;
            end else begin
              wr_data.refcount = scan_res.match_cnt - 8'd1;
            end
          end
        end
        kjst_pkg::CMD_CLEAN: begin
          if (scan_res.match_found) begin
            valid_d[scan_res.match_idx] = 1'b0;
            res_d.found_slot            = kjst_pkg::SLOTN_W'(scan_res.match_idx);
          end else begin
            res_d.status = kjst_pkg::ST_MISSING;
          end
        end
        kjst_pkg::CMD_COUNT: begin
          res_d.job_count = scan_res.total;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  assign out_o.payload = res_q;

endmodule
`default_nettype wire

// File: tb/kjst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kjst_checker: result checker for the keyed job slot table
// Watches both channels, keeps its own copy of the slot table, predicts the
// result of every accepted command and compares it field by field in order.
// ----------------------------------------------------------------------------
module kjst_checker
  import kjst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire logic      cmd_ready_i,
  input  in_item_t       cmd_item_i,
  input  wire logic      res_valid_i,
  input  wire logic      res_ready_i,
  input  out_item_t      res_item_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o,
  output int             full_seen_o
);

  localparam int MAX_REPORTS = 40;

  // Shadow copy of the slot table
  logic             used   [SLOT_COUNT];
  logic [KEY_W-1:0] job_of [SLOT_COUNT];
  logic [KEY_W-1:0] step_of[SLOT_COUNT];
  logic [REF_W-1:0] refs   [SLOT_COUNT];

  out_item_t expected_q[$];
  out_item_t want;
  int        fails;
  int        checked;
  int        full_seen;

  initial begin
    fails     = 0;
    checked   = 0;
    full_seen = 0;
  end

  // Applies one command to the shadow table and returns the result it gives
  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t r;
    int        hit;
    int        spare;
    int        sum;
    r     = '0;
    hit   = -1;
    spare = -1;
    sum   = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit < 0 && used[i] && job_of[i] == it.job_key && step_of[i] == it.step_key)
        hit = i;
      if (spare < 0 && !used[i])
        spare = i;
      if (used[i])
        sum += (refs[i] == '0) ? 1 : int'(refs[i]);
    end
    if (sum > int'(TOTAL_MAX))
      sum = int'(TOTAL_MAX);

    case (it.command)
      CMD_ATTACH: begin
        if (hit >= 0) begin
          // existing pair: bump the count, held at the top
          if (refs[hit] != REF_MAX)
            refs[hit] = refs[hit] + 1'b1;
          r.found_slot = SLOTN_W'(hit);
        end else if (spare < 0) begin
          r.status = ST_FULL;
        end else begin
          used[spare]    = 1'b1;
          job_of[spare]  = it.job_key;
          step_of[spare] = it.step_key;
          refs[spare]    = it.app_count;
          r.found_slot   = SLOTN_W'(spare);
          r.was_new      = 1'b1;
        end
      end
      CMD_FIND: begin
        if (hit >= 0)
          r.found_slot = SLOTN_W'(hit);
        else
          r.status = ST_MISSING;
      end
      CMD_END: begin
        if (int'(it.slot_number) >= SLOT_COUNT) begin
          r.status = ST_MISSING;
        end else if (!used[it.slot_number]) begin
          r.status     = ST_MISSING;
          r.found_slot = it.slot_number;
        end else begin
          r.found_slot = it.slot_number;
          // a count of zero or one releases the slot
          if (refs[it.slot_number] <= 1) begin
            refs[it.slot_number] = '0;
            used[it.slot_number] = 1'b0;
          end else begin
            refs[it.slot_number] = refs[it.slot_number] - 1'b1;
          end
        end
      end
      CMD_CLEAN: begin
        if (hit >= 0) begin
          used[hit]    = 1'b0;
          r.found_slot = SLOTN_W'(hit);
        end else begin
          r.status = ST_MISSING;
        end
      end
      CMD_COUNT: r.job_count = TOTAL_W'(sum);
      default: ;  // unused command codes give an all-zero result
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      if (fails < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      fails++;
    end
  endtask

  // Track accepted commands and compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        used[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fails < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %p", $time, res_item_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, res_item_i.status);
          check_field("found_slot", want.found_slot, res_item_i.found_slot);
          check_field("job_count", want.job_count, res_item_i.job_count);
          check_field("was_new", want.was_new, res_item_i.was_new);
          checked++;
          if (want.status == ST_FULL)
            full_seen++;
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        expected_q.push_back(apply_table_op(cmd_item_i));
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
    full_seen_o  <= full_seen;
  end

endmodule

// File: tb/tb_keyed_job_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_job_slot_table: testbench top for the keyed job slot table
// Drives directed and random command items under three idle profiles and
// leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_keyed_job_slot_table;
  import kjst_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int KEY_POOL      = 96;
  localparam int PHASE_ITEMS   = 500;
  localparam int BLOCK_ITEMS   = 50;
  localparam int FILL_ATTACHES = SLOT_COUNT + 6;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 16;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  typedef enum int {MIX_BALANCED, MIX_SHRINK, MIX_GROW} mix_e;

  logic clk_i;
  logic rst_ni;

  kjst_in_if  in_if ();
  kjst_out_if out_if ();

  int send_idle_pct = 17;
  int recv_idle_pct = 72;
  int sent          = 0;
  int cycles        = 0;
  int fail_count;
  int pending;
  int checked;
  int full_seen;

  logic [KEY_W-1:0] pool_job [KEY_POOL];
  logic [KEY_W-1:0] pool_step[KEY_POOL];

  keyed_job_slot_table DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  kjst_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_if.valid),
    .cmd_ready_i (in_if.ready),
    .cmd_item_i  (in_if.payload),
    .res_valid_i (out_if.valid),
    .res_ready_i (out_if.ready),
    .res_item_i  (out_if.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Present one item, with a random gap first; valid stays high on return
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready)
      @(posedge clk_i);
    sent++;
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] jk,
                       input logic [KEY_W-1:0] sk, input int sn, input int ac);
    in_item_t it;
    it.command     = cmd;
    it.job_key     = jk;
    it.step_key    = sk;
    it.slot_number = SLOTN_W'(sn);
    it.app_count   = REF_W'(ac);
    send_item(it);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do
      @(posedge clk_i);
    while (pending != 0);
  endtask

  // Random command; the mix decides whether the table tends to grow or shrink
  function automatic in_item_t draw_item(mix_e mix);
    in_item_t it;
    int       r;
    int       k;
    int       lim_attach;
    int       lim_find;
    int       lim_end;
    int       lim_clean;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   begin lim_attach = 65; lim_find = 75; lim_end = 83; lim_clean = 88; end
      MIX_SHRINK: begin lim_attach = 15; lim_find = 25; lim_end = 65; lim_clean = 85; end
      default:    begin lim_attach = 35; lim_find = 50; lim_end = 68; lim_clean = 80; end
    endcase
    if (r < lim_attach)      it.command = CMD_ATTACH;
    else if (r < lim_find)   it.command = CMD_FIND;
    else if (r < lim_end)    it.command = CMD_END;
    else if (r < lim_clean)  it.command = CMD_CLEAN;
    else if (r < 95)         it.command = CMD_COUNT;
    else it.command = CMD_W'($urandom_range(int'(CMD_COUNT) + 1, (1 << CMD_W) - 1));

    // keys mostly from the pool so that matches happen
    if ($urandom_range(99) < 85) begin
      k           = $urandom_range(KEY_POOL - 1);
      it.job_key  = pool_job[k];
      it.step_key = pool_step[k];
    end else begin
      it.job_key  = $urandom();
      it.step_key = $urandom();
    end
    it.slot_number = SLOTN_W'($urandom_range(SLOT_COUNT - 1));
    r = $urandom_range(99);
    if (r < 70)      it.app_count = REF_W'($urandom_range(3));
    else if (r < 85) it.app_count = REF_W'($urandom_range(int'(REF_MAX) - 5, int'(REF_MAX)));
    else             it.app_count = REF_W'($urandom_range(int'(REF_MAX)));
    return it;
  endfunction

  // Stimulus
  initial begin
    in_item_t it;
    int       n;
    int       base;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;

    // pool of key pairs; runs of three share a job key
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_job[k]  = (k % 3 == 0) ? $urandom() : pool_job[k - 1];
      pool_step[k] = $urandom();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes of keys and counts, saturation, misses
    issue(CMD_COUNT, '0, '0, 0, 0);
    issue(CMD_FIND, '0, '0, 0, 0);
    issue(CMD_END, '0, '0, 0, 0);
    issue(CMD_END, KEY_ONES, KEY_ONES, SLOT_COUNT - 1, int'(REF_MAX));
    issue(CMD_CLEAN, '0, '0, 0, 0);
    issue(CMD_ATTACH, '0, '0, 0, 0);                          // new slot, count zero
    issue(CMD_ATTACH, KEY_ONES, KEY_ONES, 0, int'(REF_MAX));
    issue(CMD_ATTACH, KEY_ONES, KEY_ONES, 0, 0);              // held at top
    issue(CMD_ATTACH, '0, KEY_ONES, 0, int'(REF_MAX) - 1);
    issue(CMD_ATTACH, '0, KEY_ONES, 0, 0);                    // reaches top
    issue(CMD_FIND, KEY_ONES, KEY_ONES, 0, 0);
    issue(CMD_FIND, '0, 1, 0, 0);                             // job key only
    issue(CMD_COUNT, '0, '0, 0, 0);
    issue(CMD_END, '0, '0, 0, 0);                             // count zero frees
    issue(CMD_END, '0, '0, 2, 0);
    issue(CMD_CLEAN, KEY_ONES, KEY_ONES, 0, 0);
    issue(CMD_ATTACH, 32'd5, 32'd6, 0, 1);                    // reuses first free
    issue(CMD_END, '0, '0, 0, 0);                             // count one frees
    issue(CMD_END, '0, '0, 1, 0);                             // already free
    for (int c = int'(CMD_COUNT) + 1; c < (1 << CMD_W); c++)
      issue(CMD_W'(c), KEY_ONES, KEY_ONES, SLOT_COUNT - 1, int'(REF_MAX));
    issue(CMD_COUNT, '0, '0, 0, 0);
    wait_drained();

    // Random part, one phase per idle profile
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin send_idle_pct = 17; recv_idle_pct = 72; end
        1:       begin send_idle_pct = 72; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      // fill past capacity with distinct pool pairs
      base = $urandom_range(KEY_POOL - 1);
      for (int i = 0; i < FILL_ATTACHES; i++)
        issue(CMD_ATTACH, pool_job[(base + i) % KEY_POOL], pool_step[(base + i) % KEY_POOL],
              $urandom_range(SLOT_COUNT - 1), $urandom_range(3));

      // random blocks with rotating mix; ignored commands are not counted
      n = 0;
      while (n < PHASE_ITEMS - FILL_ATTACHES - SLOT_COUNT) begin
        it = draw_item(mix_e'((n / BLOCK_ITEMS) % 3));
        send_item(it);
        if (it.command <= CMD_COUNT)
          n++;
      end

      // end on every slot in turn
      for (int s = 0; s < SLOT_COUNT; s++)
        issue(CMD_END, $urandom(), $urandom(), s, $urandom_range(int'(REF_MAX)));

      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d commands sent, %0d results checked, %0d table-full results",
             sent, checked, full_seen);
    $display("summary: directed edge cases, then fill, mixed and sweep under three idle mixes");
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
